FILE: rtl/core/tpfs_pkg.sv
// ----------------------------------------------------------------------------
// Thermal pixel frame statistics package
// Shared types, constants and field widths of the statistics block.
// ----------------------------------------------------------------------------
package tpfs_pkg;

  localparam int unsigned TableDepth = 257;
  localparam int unsigned TableAw    = 9;
  localparam int unsigned MaxPixels  = 1048576;
  localparam int unsigned CountW     = 21;
  localparam int unsigned SumW       = 44;
  localparam int unsigned CfgAw      = 2;
  localparam int unsigned CfgDw      = 24;

  localparam logic signed [23:0] InitMin = 24'sd128000;
  localparam logic signed [23:0] InitMax = -24'sd128000;
  localparam logic signed [23:0] TempMax = 24'sh7FFFFF;
  localparam logic signed [23:0] TempMin = 24'sh800000;

  localparam logic [CfgAw-1:0] RegEnable = 2'd0;
  localparam logic [CfgAw-1:0] RegGain   = 2'd1;
  localparam logic [CfgAw-1:0] RegBias   = 2'd2;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpPixel = 1'b1;

  typedef struct packed {
    logic              op;
    logic [8:0]        table_index;
    logic signed [23:0] table_value;
    logic [15:0]       pixel_code;
    logic [15:0]       pixel_x;
    logic [15:0]       pixel_y;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] temperature;
    logic              stats_valid;
    logic signed [23:0] low_temp;
    logic [15:0]       min_col;
    logic [15:0]       min_row;
    logic [15:0]       min_code;
    logic signed [23:0] high_temp;
    logic [15:0]       max_col;
    logic [15:0]       max_row;
    logic [15:0]       max_code;
    logic signed [23:0] mean_temperature;
  } out_item_t;

  // Entry of the queue between the converter and the statistics back end.
  typedef struct packed {
    logic signed [23:0] temperature;
    logic [15:0]       code;
    logic [15:0]       x;
    logic [15:0]       y;
    logic              last;
  } pix_t;

endpackage

FILE: rtl/core/tpfs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tpfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

FILE: rtl/core/tpfs_front.sv
// ----------------------------------------------------------------------------
// Front end: table load and pixel conversion
// Accepts items, writes table entries, reads two neighboring entries from two
// table copies, interpolates and applies the optional correction.
// ----------------------------------------------------------------------------
module tpfs_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tpfs_pkg::in_item_t     in_data,
  input  logic                   cor_en_i,
  input  logic signed [23:0]     cor_gain_i,
  input  logic signed [23:0]     cor_bias_i,
  output logic                   pix_valid_o,
  input  logic                   pix_ready_i,
  output tpfs_pkg::pix_t         pix_o
);
  import tpfs_pkg::*;

  // Stage 1: table read. Stage 2: interpolation product. Stage 3: correction
  // product. Stage 4: shift, bias, saturate.
  logic        v1_q, v2_q, v3_q, v4_q;
  logic        stall;
  logic        ld, px;
  logic [TableAw-1:0] ra0, ra1;
  logic signed [23:0] t1, t2;
  logic [7:0]  lo1_q;
  pix_t        m1_q, m2_q, m3_q, m4_q;
  logic signed [24:0] diff;
  logic signed [33:0] prod2_q;
  logic signed [23:0] t1_2_q;
  logic signed [25:0] tint;
  logic signed [23:0] tint24;
  logic signed [47:0] prod3_q;
  logic        en3_q;
  logic signed [24:0] tpass3_q;
  logic signed [33:0] corr;
  logic signed [23:0] tfinal;
  logic signed [23:0] t4_q;

  assign stall    = v4_q && !pix_ready_i;
  assign in_ready = !stall;
  assign ld = in_valid && in_ready && (in_data.op == OpLoad);
  assign px = in_valid && in_ready && (in_data.op == OpPixel);
  assign ra0 = {1'b0, in_data.pixel_code[15:8]};
  assign ra1 = {1'b0, in_data.pixel_code[15:8]} + 9'd1;

  tpfs_ram #(.Width(24), .Depth(TableDepth), .Aw(TableAw)) u_tab0 (
    .clk_i, .we_i(ld && in_data.table_index < TableAw'(TableDepth)),
    .waddr_i(in_data.table_index), .wdata_i(in_data.table_value),
    .re_i(px), .raddr_i(ra0), .rdata_o(t1)
  );
  tpfs_ram #(.Width(24), .Depth(TableDepth), .Aw(TableAw)) u_tab1 (
    .clk_i, .we_i(ld && in_data.table_index < TableAw'(TableDepth)),
    .waddr_i(in_data.table_index), .wdata_i(in_data.table_value),
    .re_i(px), .raddr_i(ra1), .rdata_o(t2)
  );

  assign diff   = 25'(t2) - 25'(t1);
  assign tint   = 26'(t1_2_q) + 26'(prod2_q >>> 8);
  assign tint24 = tint[23:0];
  assign corr   = 34'(prod3_q >>> 16) + 34'(cor_bias_i);

  always_comb begin
    if (!en3_q) begin
      tfinal = tpass3_q[23:0];
    end else if (corr > 34'(TempMax)) begin
      tfinal = TempMax;
    end else if (corr < 34'(TempMin)) begin
      tfinal = TempMin;
    end else begin
      tfinal = corr[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (!stall) begin
      v1_q <= px;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      m1_q     <= '{temperature: '0, code: in_data.pixel_code, x: in_data.pixel_x,
                    y: in_data.pixel_y, last: in_data.frame_end};
      lo1_q    <= in_data.pixel_code[7:0];
      m2_q     <= m1_q;
      prod2_q  <= 34'(diff) * $signed({1'b0, lo1_q});
      t1_2_q   <= t1;
      m3_q     <= m2_q;
      prod3_q  <= 48'(tint24) * 48'(cor_gain_i);
      tpass3_q <= 25'(tint24);
      en3_q    <= cor_en_i;
      m4_q     <= m3_q;
      t4_q     <= tfinal;
    end
  end

  always_comb begin
    pix_o             = m4_q;
    pix_o.temperature = t4_q;
  end
  assign pix_valid_o = v4_q;
endmodule

FILE: rtl/core/tpfs_fifo.sv
// ----------------------------------------------------------------------------
// Pixel queue
// Two-entry queue that decouples the converter from the statistics unit.
// ----------------------------------------------------------------------------
module tpfs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wvalid_i,
  output logic            wready_o,
  input  tpfs_pkg::pix_t  wdata_i,
  output logic            rvalid_o,
  input  logic            rready_i,
  output tpfs_pkg::pix_t  rdata_o
);
  import tpfs_pkg::*;

  pix_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wready_o = cnt_q != 2'd2;
  assign rvalid_o = cnt_q != 2'd0;
  assign rdata_o  = mem_q[rp_q];
  assign wr = wvalid_i && wready_o;
  assign rd = rvalid_o && rready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wdata_i;
  end
endmodule

FILE: rtl/core/tpfs_stats.sv
// ----------------------------------------------------------------------------
// Statistics back end
// Tracks min, max, sum and count; divides for the mean at frame end with a
// restoring divider, one quotient bit per cycle; holds the result register.
// ----------------------------------------------------------------------------
module tpfs_stats (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pix_valid_i,
  output logic                  pix_ready_o,
  input  tpfs_pkg::pix_t        pix_i,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tpfs_pkg::out_item_t   out_data
);
  import tpfs_pkg::*;

  typedef enum logic [1:0] {StRun, StDiv, StEmit} state_e;

  localparam int unsigned DivSteps = SumW;

  state_e              state_q;
  logic signed [23:0]  min_q, max_q;
  logic [15:0]         mnc_q, mnr_q, mnk_q, mxc_q, mxr_q, mxk_q;
  logic signed [SumW-1:0] sum_q;
  logic [CountW-1:0]   cnt_q;
  out_item_t           res_q;
  logic                ov_q;
  logic [SumW-1:0]     dq_q;
  logic [CountW:0]     rem_q;
  logic [CountW-1:0]   den_q;
  logic                neg_q;
  logic [5:0]          step_q;

  logic                take;
  logic                ov_set;
  logic signed [23:0]  t;
  logic signed [23:0]  min_d, max_d;
  logic [15:0]         mnc_d, mnr_d, mnk_d, mxc_d, mxr_d, mxk_d;
  logic signed [SumW-1:0] sum_d;
  logic [CountW-1:0]   cnt_d;
  logic                add;
  logic [SumW-1:0]     mag;
  logic [CountW+1:0]   trial;
  logic [SumW-1:0]     qneg;

  assign t    = pix_i.temperature;
  assign take = pix_valid_i && pix_ready_o;
  assign pix_ready_o = (state_q == StRun) && (!ov_q || out_ready);
  assign out_valid = ov_q;
  assign out_data  = res_q;
  assign add  = cnt_q < CountW'(MaxPixels);
  assign ov_set = (take && !pix_i.last) ||
                  ((state_q == StEmit) && (!ov_q || out_ready));

  always_comb begin
    sum_d = add ? sum_q + SumW'(t) : sum_q;
    cnt_d = add ? cnt_q + 1'b1 : cnt_q;
    min_d = min_q; mnc_d = mnc_q; mnr_d = mnr_q; mnk_d = mnk_q;
    max_d = max_q; mxc_d = mxc_q; mxr_d = mxr_q; mxk_d = mxk_q;
    if (t < min_q) begin
      min_d = t; mnc_d = pix_i.x; mnr_d = pix_i.y; mnk_d = pix_i.code;
    end
    if (t > max_q) begin
      max_d = t; mxc_d = pix_i.x; mxr_d = pix_i.y; mxk_d = pix_i.code;
    end
    mag = sum_d[SumW-1] ? SumW'(-sum_d) : SumW'(sum_d);
  end

  assign trial = {rem_q, dq_q[SumW-1]} - {2'b00, den_q};
  assign qneg  = neg_q ? SumW'(-dq_q) : dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
      ov_q    <= 1'b0;
      res_q   <= '0;
      min_q   <= InitMin;
      max_q   <= InitMax;
      mnc_q <= '0; mnr_q <= '0; mnk_q <= '0;
      mxc_q <= '0; mxr_q <= '0; mxk_q <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      dq_q    <= '0;
      rem_q   <= '0;
      den_q   <= '0;
      neg_q   <= 1'b0;
      step_q  <= '0;
    end else begin
      if (ov_set) begin
        ov_q <= 1'b1;
      end else if (out_ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        StRun: begin
          if (take) begin
            if (pix_i.last) begin
              res_q.temperature     <= t;
              res_q.stats_valid     <= 1'b1;
              res_q.low_temp        <= min_d;
              res_q.min_col <= mnc_d; res_q.min_row <= mnr_d; res_q.min_code <= mnk_d;
              res_q.high_temp       <= max_d;
              res_q.max_col <= mxc_d; res_q.max_row <= mxr_d; res_q.max_code <= mxk_d;
              dq_q   <= mag;
              neg_q  <= sum_d[SumW-1];
              den_q  <= cnt_d;
              rem_q  <= '0;
              step_q <= '0;
              state_q <= StDiv;
              min_q <= InitMin; max_q <= InitMax;
              mnc_q <= '0; mnr_q <= '0; mnk_q <= '0;
              mxc_q <= '0; mxr_q <= '0; mxk_q <= '0;
              sum_q <= '0; cnt_q <= '0;
            end else begin
              res_q <= '{temperature: t, default: '0};
              min_q <= min_d; mnc_q <= mnc_d; mnr_q <= mnr_d; mnk_q <= mnk_d;
              max_q <= max_d; mxc_q <= mxc_d; mxr_q <= mxr_d; mxk_q <= mxk_d;
              sum_q <= sum_d; cnt_q <= cnt_d;
            end
          end
        end
        StDiv: begin
          if (!trial[CountW+1]) begin
            rem_q <= trial[CountW:0];
            dq_q  <= {dq_q[SumW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[CountW-1:0], dq_q[SumW-1]};
            dq_q  <= {dq_q[SumW-2:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == 6'(DivSteps - 1)) state_q <= StEmit;
        end
        StEmit: begin
          if (!ov_q || out_ready) begin
            res_q.mean_temperature <= qneg[23:0];
            state_q <= StRun;
          end
        end
        default: state_q <= StRun;
      endcase
    end
  end
endmodule

FILE: rtl/core/thermal_pixel_frame_statistics.sv
// ----------------------------------------------------------------------------
// Thermal pixel frame statistics
// Calibration table lookup with interpolation, correction and frame stats.
// ----------------------------------------------------------------------------
// Table loads and pixels enter at one item per cycle while the converter is
// not stalled; a pixel's result passes through a four-stage converter, a
// two-entry queue and the result register before it is offered. A frame's
// last pixel holds the statistics unit while the restoring divider forms the
// mean one quotient bit per cycle and the mean is loaded into the result.
module thermal_pixel_frame_statistics (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tpfs_pkg::in_item_t            in_data,
  input  logic                          cfg_we_i,
  input  logic [tpfs_pkg::CfgAw-1:0]    cfg_idx_i,
  input  logic [tpfs_pkg::CfgDw-1:0]    cfg_data_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tpfs_pkg::out_item_t           out_data
);
  import tpfs_pkg::*;

  logic               en_q;
  logic signed [23:0] gain_q, bias_q;
  logic               fv, fr, qv, qr;
  pix_t               fp, qp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      gain_q <= 24'sd65536;
      bias_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegEnable: en_q   <= cfg_data_i[0];
        RegGain:   gain_q <= cfg_data_i;
        RegBias:   bias_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpfs_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data,
    .cor_en_i(en_q), .cor_gain_i(gain_q), .cor_bias_i(bias_q),
    .pix_valid_o(fv), .pix_ready_i(fr), .pix_o(fp)
  );

  tpfs_fifo u_fifo (
    .clk_i, .rst_ni, .wvalid_i(fv), .wready_o(fr), .wdata_i(fp),
    .rvalid_o(qv), .rready_i(qr), .rdata_o(qp)
  );

  tpfs_stats u_stats (
    .clk_i, .rst_ni, .pix_valid_i(qv), .pix_ready_o(qr), .pix_i(qp),
    .out_valid, .out_ready, .out_data
  );
endmodule

FILE: rtl/core/tpfs_checker.sv
// ----------------------------------------------------------------------------
// Thermal pixel frame statistics checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tpfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid,
  input logic                out_ready,
  input tpfs_pkg::out_item_t out_data
);
  import tpfs_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.stats_valid |-> out_data.low_temp == '0
      && out_data.mean_temperature == '0)
    else $error("Statistics present without stats_valid.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.stats_valid |->
      out_data.low_temp <= InitMin && out_data.high_temp >= InitMax)
    else $error("Extremum beyond its initial value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.stats_valid && out_data.low_temp != InitMin
      && out_data.high_temp != InitMax |->
      out_data.low_temp <= out_data.high_temp)
    else $error("Minimum above maximum.");
endmodule

bind thermal_pixel_frame_statistics tpfs_checker u_tpfs_checker (
  .clk_i, .rst_ni, .out_valid, .out_ready, .out_data
);
